// File: rtl/sove_pkg.sv
// Shared types and constants for the meter frame value extractor.
`timescale 1ns / 1ps

package sove_pkg;

	// Default sizing
	localparam int MAX_FRAME_BYTES_DEF = 1024;
	localparam int CODE_BYTES_DEF      = 8;
	localparam int NUM_CODES_DEF       = 3;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CODE_FIRST   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_FIRST = 3'd3;

	// Register reset values, entry 0 belongs to the first code
	localparam logic [2:0][63:0] CODE_RESET = {
		64'h7707_0100_1007_00FF,
		64'h7707_0100_0208_00FF,
		64'h7707_0100_0108_00FF
	};
	localparam logic [2:0][7:0] OFFSET_RESET = {8'd15, 8'd15, 8'd19};

	// Per-code result as seen after the current byte
	typedef struct packed {
		logic        found;
		logic        complete;
		logic [31:0] value;
	} code_res_t;

endpackage

// File: rtl/sove_byte_cell.sv
// One byte cell of the search window: holds a byte and extends the match chain.
`timescale 1ns / 1ps

module sove_byte_cell #(
	parameter int NUM_CODES = 3
) (
	input  logic                      clk,
	input  logic                      advance,
	input  logic [7:0]                byte_in,
	input  logic [NUM_CODES-1:0]      match_in,
	input  logic [NUM_CODES-1:0][7:0] code_bytes,
	output logic [7:0]                byte_out,
	output logic [NUM_CODES-1:0]      match_out
);
	import sove_pkg::*;

	logic [7:0] byte_q;

	// Compare the byte entering this place of the window with each code byte
	always_comb begin
		for (int k = 0; k < NUM_CODES; k++) begin
			match_out[k] = match_in[k] && (byte_in == code_bytes[k]);
		end
	end

	// Hand the byte on to the next cell
	always_ff @(posedge clk) begin
		if (advance) begin
			byte_q <= byte_in;
		end
	end

	assign byte_out = byte_q;

endmodule

// File: rtl/sove_tracker.sv
// Per-code tracker: waits for the type-length byte and gathers the value.
`timescale 1ns / 1ps

module sove_tracker #(
	parameter int CODE_BYTES = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 advance,
	input  logic                 clear,
	input  logic                 hit,
	input  logic [7:0]           data,
	input  logic [7:0]           offset,
	output sove_pkg::code_res_t  res
);
	import sove_pkg::*;

	typedef enum logic [3:0] {
		PH_SEARCH = 4'b0001,
		PH_TYPE   = 4'b0010,
		PH_GATHER = 4'b0100,
		PH_DONE   = 4'b1000
	} phase_t;

	localparam logic [7:0] CB = 8'(CODE_BYTES);

	phase_t      phase_q, phase_d;
	logic [7:0]  cd_q, cd_d;
	logic [3:0]  rem_q, rem_d;
	logic [31:0] acc_q, acc_d;
	logic        sgn_q, sgn_d;
	logic [3:0]  nib;

	assign nib = data[3:0];

	// Next state for the current byte
	always_comb begin
		phase_d = phase_q;
		cd_d    = cd_q;
		rem_d   = rem_q;
		acc_d   = acc_q;
		sgn_d   = sgn_q;
		if (advance) begin
			case (phase_q)
				PH_SEARCH: begin
					if (hit) begin
						cd_d    = (offset > CB) ? (offset - CB - 8'd1) : 8'd0;
						phase_d = PH_TYPE;
					end
				end
				PH_TYPE: begin
					if (cd_q != 8'd0) begin
						cd_d = cd_q - 8'd1;
					end else begin
						acc_d = '0;
						if (nib inside {4'd0, 4'd1}) begin
							phase_d = PH_DONE;
						end else begin
							rem_d   = nib - 4'd1;
							sgn_d   = (nib == 4'd2);
							phase_d = PH_GATHER;
						end
					end
				end
				PH_GATHER: begin
					acc_d = sgn_q ? {{24{data[7]}}, data} : {acc_q[23:0], data};
					rem_d = rem_q - 4'd1;
					if (rem_d == 4'd0) begin
						phase_d = PH_DONE;
					end
				end
				PH_DONE: begin
				end
				default: phase_d = PH_SEARCH;
			endcase
		end
	end

	// Result after this byte, taken by the output stage on frame end
	always_comb begin
		res.found    = (phase_d != PH_SEARCH);
		res.complete = (phase_d == PH_DONE);
		res.value    = (phase_d == PH_DONE) ? acc_d : 32'd0;
	end

	// Phase register, back to searching at the end of each frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SEARCH;
		end else if (clear) begin
			phase_q <= PH_SEARCH;
		end else begin
			phase_q <= phase_d;
		end
	end

	// Counters and accumulator, always loaded before use
	always_ff @(posedge clk) begin
		cd_q  <= cd_d;
		rem_q <= rem_d;
		acc_q <= acc_d;
		sgn_q <= sgn_d;
	end

endmodule

// File: rtl/sml_obis_value_extractor_unit.sv
// Top level of the meter frame value extractor: window cells, trackers and result stage.
`timescale 1ns / 1ps

//  channel | signals                                    | role
//  --------+--------------------------------------------+-------------------------------
//  in      | in_valid, in_ready, data_byte, frame_end   | one frame byte per item
//  out     | out_valid, out_ready, code_index, found,   | NUM_CODES items per frame end
//          | complete, value, last_of_run               |
//  cfg     | cfg_we, cfg_index, cfg_data                | register writes, no wait
//
// One frame byte is taken every cycle; matching and gathering finish in the cycle the
// byte arrives. A frame-end byte loads NUM_CODES results into the output stage, which
// hands out one per cycle while out_ready is high, from the next cycle on, so a frame end
// waits while results of the previous frame are undelivered, but is taken in the cycle the
// last of them leaves. Other bytes never wait. Reset restores the register defaults and
// clears frame state; there is no clearing pass.

module sml_obis_value_extractor_unit #(
	parameter int MAX_FRAME_BYTES = sove_pkg::MAX_FRAME_BYTES_DEF,
	parameter int CODE_BYTES      = sove_pkg::CODE_BYTES_DEF,
	parameter int NUM_CODES       = sove_pkg::NUM_CODES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [7:0]                      data_byte,
	input  logic                            frame_end,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [1:0]                      code_index,
	output logic                            found,
	output logic                            complete,
	output logic [31:0]                     value,
	output logic                            last_of_run,
	input  logic                            cfg_we,
	input  logic [sove_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sove_pkg::CFG_DATA_W-1:0] cfg_data
);
	import sove_pkg::*;

	localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);
	localparam int CNT_W = $clog2(NUM_CODES + 1);

	// Configuration registers
	logic [NUM_CODES-1:0][63:0] code_q;
	logic [NUM_CODES-1:0][7:0]  offset_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_CODES; k++) begin
				code_q[k]   <= CODE_RESET[k];
				offset_q[k] <= OFFSET_RESET[k];
			end
		end else if (cfg_we) begin
			for (int k = 0; k < NUM_CODES; k++) begin
				if (cfg_index == REG_CODE_FIRST + CFG_IDX_W'(k)) begin
					code_q[k] <= cfg_data;
				end
				if (cfg_index == REG_OFFSET_FIRST + CFG_IDX_W'(k)) begin
					offset_q[k] <= cfg_data[7:0];
				end
			end
		end
	end

	// Handshake and frame position
	logic             in_acc, advance, clear, buf_free, pop, full;
	logic [POS_W-1:0] pos_q;
	logic [CNT_W-1:0] cnt_q;

	assign pop      = out_valid && out_ready;
	assign buf_free = (cnt_q == '0) || ((cnt_q == CNT_W'(1)) && out_ready);
	assign in_ready = frame_end ? buf_free : 1'b1;
	assign in_acc   = in_valid && in_ready;
	assign advance  = in_acc && (pos_q < POS_W'(MAX_FRAME_BYTES));
	assign clear    = in_acc && frame_end;
	assign full     = (pos_q >= POS_W'(CODE_BYTES - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (clear) begin
			pos_q <= '0;
		end else if (advance) begin
			pos_q <= pos_q + POS_W'(1);
		end
	end

	// Chain of window cells; cell j sees the byte j places back
	logic [CODE_BYTES:0][7:0]          chain_byte;
	logic [CODE_BYTES:0][NUM_CODES-1:0] chain_match;

	assign chain_byte[0]  = data_byte;
	assign chain_match[0] = '1;

	for (genvar j = 0; j < CODE_BYTES; j++) begin : g_cell
		logic [NUM_CODES-1:0][7:0] cb;
		for (genvar k = 0; k < NUM_CODES; k++) begin : g_cb
			assign cb[k] = code_q[k][8*j +: 8];
		end
		sove_byte_cell #(
			.NUM_CODES (NUM_CODES)
		) u_cell (
			.clk        (clk),
			.advance    (advance),
			.byte_in    (chain_byte[j]),
			.match_in   (chain_match[j]),
			.code_bytes (cb),
			.byte_out   (chain_byte[j+1]),
			.match_out  (chain_match[j+1])
		);
	end

	// One tracker per code
	code_res_t [NUM_CODES-1:0] trk_res;

	for (genvar k = 0; k < NUM_CODES; k++) begin : g_trk
		sove_tracker #(
			.CODE_BYTES (CODE_BYTES)
		) u_trk (
			.clk     (clk),
			.arst_n  (arst_n),
			.advance (advance),
			.clear   (clear),
			.hit     (full && chain_match[CODE_BYTES][k]),
			.data    (data_byte),
			.offset  (offset_q[k]),
			.res     (trk_res[k])
		);
	end

	// Result stage: loaded on frame end, shifted out one item per cycle while out_ready is high
	code_res_t [NUM_CODES-1:0] slot_q;
	logic [1:0]                idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			idx_q <= '0;
		end else if (clear) begin
			cnt_q <= CNT_W'(NUM_CODES);
			idx_q <= '0;
		end else if (pop) begin
			cnt_q <= cnt_q - CNT_W'(1);
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (clear) begin
			slot_q <= trk_res;
		end else if (pop) begin
			for (int k = 0; k < NUM_CODES - 1; k++) begin
				slot_q[k] <= slot_q[k+1];
			end
		end
	end

	assign out_valid   = (cnt_q != '0);
	assign code_index  = idx_q;
	assign found       = slot_q[0].found;
	assign complete    = slot_q[0].complete;
	assign value       = slot_q[0].value;
	assign last_of_run = (cnt_q == CNT_W'(1));

endmodule
